// File: sv/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature scanner.
package wbss_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int WORD_W   = 64;
	localparam int WORDS    = 4;
	localparam int OFS_W    = 32;
	localparam int TOTAL_W  = 16;
	localparam int STATUS_W = 2;
	localparam int REG_IDX_W = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_MID = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PAT_TOP = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd5;

	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MULTI  = 2'd2;

	// one classified byte, front to back
	typedef struct packed {
		logic hit;
		logic last;
	} scan_entry_t;

endpackage

// File: sv/wbss_byte_if.sv
// Input channel: one byte of the scanned region per transfer.
interface wbss_byte_if;
	logic                       valid;
	logic                       ready;
	logic [wbss_pkg::BYTE_W-1:0] data_byte;
	logic                       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: sv/wbss_report_if.sv
// Output channel: match reports and end of region summaries.
interface wbss_report_if;
	logic                          valid;
	logic                          ready;
	logic                          report_kind;
	logic [wbss_pkg::OFS_W-1:0]    match_offset;
	logic [wbss_pkg::TOTAL_W-1:0]  match_total;
	logic [wbss_pkg::STATUS_W-1:0] scan_status;
	logic                          run_end;

	modport source (output valid, output report_kind, output match_offset,
		output match_total, output scan_status, output run_end, input ready);
	modport sink (input valid, input report_kind, input match_offset,
		input match_total, input scan_status, input run_end, output ready);
endinterface

// File: sv/wildcard_byte_signature_scan.sv
// A byte's match report passes through the queue and then the output register to the output.
// Throughput: one byte per cycle while the queue is not full; a final byte that also matches
// gives a match report and a summary, which leave the output register one after the other.
// Reset: arst_n clears all region state and sets pattern_length 1, pattern bytes and limit 0;
// no clearing pass, the block takes bytes as soon as reset is released.
module wildcard_byte_signature_scan #(
	parameter int PATTERN_MAX  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wbss_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [wbss_pkg::WORD_W-1:0]       cfg_data,
	wbss_byte_if.sink                         bytes,
	wbss_report_if.source                     reports
);

	logic [wbss_pkg::LEN_W-1:0]                  len_q;
	logic [wbss_pkg::WORDS-1:0][wbss_pkg::WORD_W-1:0] pat_q;
	logic [wbss_pkg::TOTAL_W-1:0]                limit_q;
	logic [wbss_pkg::LEN_W-1:0]                  used_len;

	logic                  q_full, push, pop, head_valid;
	wbss_pkg::scan_entry_t push_entry, head;

	// zero length acts as one, anything past the window depth is clamped
	assign used_len = (len_q == '0) ? 6'd1 :
	                  (len_q > 6'(PATTERN_MAX)) ? 6'(PATTERN_MAX) : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 6'd1;
			pat_q   <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbss_pkg::REG_LENGTH:  len_q    <= cfg_data[wbss_pkg::LEN_W-1:0];
				wbss_pkg::REG_PAT_LO:  pat_q[0] <= cfg_data;
				wbss_pkg::REG_PAT_MID: pat_q[1] <= cfg_data;
				wbss_pkg::REG_PAT_HI:  pat_q[2] <= cfg_data;
				wbss_pkg::REG_PAT_TOP: pat_q[3] <= cfg_data;
				wbss_pkg::REG_LIMIT:   limit_q  <= cfg_data[wbss_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	wbss_front #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.used_len   (used_len),
		.pattern    (pat_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	wbss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	wbss_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.used_len   (used_len),
		.limit      (limit_q),
		.reports    (reports)
	);

endmodule

// File: sv/wbss_front.sv
// Front end: byte window shift register and parallel wildcard compare.
module wbss_front #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	wbss_byte_if.sink                                       bytes,
	input  logic [wbss_pkg::LEN_W-1:0]                      used_len,
	input  logic [wbss_pkg::WORDS*wbss_pkg::WORD_W-1:0]     pattern,
	input  logic                                            q_full,
	output logic                                            push,
	output wbss_pkg::scan_entry_t                           push_entry
);

	localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	logic [wbss_pkg::BYTE_W-1:0] win_q [PATTERN_MAX];
	logic [wbss_pkg::BYTE_W-1:0] win_next [PATTERN_MAX];
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           fill_next;
	logic [PATTERN_MAX-1:0]      byte_ok;
	logic                        full_enough;

	assign bytes.ready = !q_full;
	assign push        = bytes.valid && !q_full;

	always_comb begin
		win_next[0] = bytes.data_byte;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	assign fill_next = (fill_q < FILL_W'(PATTERN_MAX)) ? fill_q + 1'b1 : fill_q;
	assign full_enough = {{(7-FILL_W){1'b0}}, fill_next} >= {1'b0, used_len};

	// pattern byte j lines up with the window byte len-1-j back from the newest
	always_comb begin
		logic [wbss_pkg::LEN_W-1:0] k;
		logic [wbss_pkg::BYTE_W-1:0] p;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			k = used_len - 6'd1 - 6'(j);
			p = pattern[j*wbss_pkg::BYTE_W +: wbss_pkg::BYTE_W];
			byte_ok[j] = (6'(j) >= used_len) || (p == '0) || (win_next[k[IDX_W-1:0]] == p);
		end
	end

	assign push_entry.hit  = full_enough && (&byte_ok);
	assign push_entry.last = bytes.final_byte;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

	// fill restarts at the region boundary, so stale window bytes are never tested
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			fill_q <= bytes.final_byte ? '0 : fill_next;
		end
	end

endmodule

// File: sv/wbss_queue.sv
// Two-entry queue between the classifying front end and the report back end.
module wbss_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  wbss_pkg::scan_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output wbss_pkg::scan_entry_t head
);

	wbss_pkg::scan_entry_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/wbss_back.sv
// Back end: start ordering, match counting, limit and region summary reports.
module wbss_back #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  wbss_pkg::scan_entry_t            head,
	output logic                             pop,
	input  logic [wbss_pkg::LEN_W-1:0]       used_len,
	input  logic [wbss_pkg::TOTAL_W-1:0]     limit,
	wbss_report_if.source                    reports
);

	logic [OFFSET_WIDTH-1:0]      pos_q;
	logic [OFFSET_WIDTH-1:0]      next_start_q;
	logic [OFFSET_WIDTH-1:0]      first_ofs_q;
	logic [wbss_pkg::TOTAL_W-1:0] found_q;
	logic                         phase_q;   // match of a final byte already sent
	logic                         out_valid_q;

	logic [OFFSET_WIDTH-1:0]      len_ext;
	logic [OFFSET_WIDTH-1:0]      start;
	logic [OFFSET_WIDTH+31:0]     start_wide;
	logic [OFFSET_WIDTH+31:0]     first_wide;
	logic [wbss_pkg::TOTAL_W-1:0] found_inc;
	logic limit_ok, do_match, do_sum, need_out, out_free, step;

	assign len_ext   = {{(OFFSET_WIDTH-wbss_pkg::LEN_W){1'b0}}, used_len};
	assign start     = pos_q + 1'b1 - len_ext;
	assign start_wide = {32'd0, start};
	assign first_wide = {32'd0, first_ofs_q};
	assign found_inc = (found_q != '1) ? found_q + 1'b1 : found_q;
	assign limit_ok  = (limit == '0) || (found_q < limit);

	assign do_match = head_valid && !phase_q && head.hit && limit_ok && (start >= next_start_q);
	assign do_sum   = head_valid && head.last && !do_match;
	assign need_out = do_match || do_sum;
	assign out_free = !out_valid_q || reports.ready;
	assign step     = head_valid && (!need_out || out_free);
	assign pop      = step && !(do_match && head.last);

	assign reports.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			phase_q      <= 1'b0;
			pos_q        <= '0;
			next_start_q <= '0;
			first_ofs_q  <= '0;
			found_q      <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= step && need_out;
			end
			if (step) begin
				if (do_match) begin
					if (found_q == '0) begin
						first_ofs_q <= start;
					end
					found_q      <= found_inc;
					next_start_q <= start + len_ext;
					pos_q        <= pos_q + 1'b1;
					phase_q      <= head.last;
				end else if (do_sum) begin
					pos_q        <= '0;
					next_start_q <= '0;
					first_ofs_q  <= '0;
					found_q      <= '0;
					phase_q      <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && need_out) begin
			if (do_match) begin
				reports.report_kind  <= wbss_pkg::KIND_MATCH;
				reports.match_offset <= start_wide[31:0];
				reports.match_total  <= found_inc;
				reports.scan_status  <= wbss_pkg::STATUS_SINGLE;
				reports.run_end      <= !head.last;
			end else begin
				reports.report_kind  <= wbss_pkg::KIND_SUMMARY;
				reports.match_offset <= (found_q == 16'd1) ? first_wide[31:0] : '0;
				reports.match_total  <= found_q;
				reports.scan_status  <= (found_q == '0)    ? wbss_pkg::STATUS_NONE :
				                        (found_q == 16'd1) ? wbss_pkg::STATUS_SINGLE :
				                                             wbss_pkg::STATUS_MULTI;
				reports.run_end      <= 1'b1;
			end
		end
	end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the wildcard byte signature scanner.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_MAX     = 32;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int HOLD_CYCLES = 400;

	// indexes past the last register; writes there must be dropped
	localparam logic [wbss_pkg::REG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [wbss_pkg::REG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

	typedef struct packed {
		logic [wbss_pkg::BYTE_W-1:0] data;
		logic                        last;
	} region_byte_t;

	typedef struct packed {
		logic                          kind;
		logic [wbss_pkg::OFS_W-1:0]    ofs;
		logic [wbss_pkg::TOTAL_W-1:0]  total;
		logic [wbss_pkg::STATUS_W-1:0] status;
		logic                          run_end;
	} scan_report_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [wbss_pkg::REG_IDX_W-1:0] cfg_index;
	logic [wbss_pkg::WORD_W-1:0]    cfg_data;

	wbss_byte_if   byte_ch();
	wbss_report_if report_ch();

	wildcard_byte_signature_scan dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (byte_ch),
		.reports   (report_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// register shadow
	logic [wbss_pkg::LEN_W-1:0]   cfg_len = 6'd1;
	logic [wbss_pkg::WORD_W-1:0]  cfg_pat [wbss_pkg::WORDS] = '{default: '0};
	logic [wbss_pkg::TOTAL_W-1:0] cfg_limit = '0;

	// scanner state as predicted
	logic [wbss_pkg::BYTE_W-1:0]  win [PAT_MAX] = '{default: '0};
	logic [wbss_pkg::OFS_W-1:0]   pos = '0;
	logic [wbss_pkg::TOTAL_W-1:0] found = '0;
	logic [wbss_pkg::OFS_W-1:0]   next_start = '0;
	logic [wbss_pkg::OFS_W-1:0]   first_ofs = '0;
	int unsigned                  fill = 0;

	region_byte_t  region_bytes_q [$];
	scan_report_t  owed_reports [$];
	logic [wbss_pkg::BYTE_W-1:0] pat_gen [PAT_MAX];

	int queued_bytes   = 0;
	int accepted_bytes = 0;
	int random_items   = 0;
	int mismatches     = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int cycles         = 0;

	function automatic int unsigned used_len();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > PAT_MAX)
			return PAT_MAX;
		return cfg_len;
	endfunction

	function automatic logic [wbss_pkg::BYTE_W-1:0] data_pick();
		if ($urandom_range(0, 9) < 7)
			return 8'h41 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [wbss_pkg::BYTE_W-1:0] pat_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return '0;
		if (r < 8)
			return 8'h41 + 8'($urandom_range(0, 3));
		if (r == 8)
			return 8'hFF;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [wbss_pkg::WORD_W-1:0] pattern_word(input int k);
		logic [wbss_pkg::WORD_W-1:0] w;
		int b;
		for (b = 0; b < 8; b++)
			w[b*8 +: 8] = pat_gen[k*8 + b];
		return w;
	endfunction

	// advance the scanner by one byte and record the reports it owes
	task automatic scan_byte(input logic [wbss_pkg::BYTE_W-1:0] b, input logic fin);
		int unsigned n;
		int i;
		logic [wbss_pkg::OFS_W-1:0] start;
		logic [wbss_pkg::BYTE_W-1:0] p;
		logic [wbss_pkg::STATUS_W-1:0] st;
		bit hit;
		n = used_len();
		for (i = PAT_MAX - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = b;
		if (fill < PAT_MAX)
			fill++;
		if (fill >= n && (cfg_limit == 0 || found < cfg_limit)) begin
			start = pos + 1 - n;
			if (start >= next_start) begin
				hit = 1'b1;
				for (i = 0; i < n; i++) begin
					p = cfg_pat[i / 8][(i % 8) * 8 +: 8];
					if (p != 0 && win[n - 1 - i] != p)
						hit = 1'b0;
				end
				if (hit) begin
					if (found == 0)
						first_ofs = start;
					if (found != '1)
						found++;
					next_start = start + n;
					// status field reads zero on a match report
					owed_reports.push_back('{wbss_pkg::KIND_MATCH, start, found, '0, !fin});
				end
			end
		end
		pos = pos + 1;
		if (fin) begin
			if (found == 0)
				st = wbss_pkg::STATUS_NONE;
			else if (found == 1)
				st = wbss_pkg::STATUS_SINGLE;
			else
				st = wbss_pkg::STATUS_MULTI;
			owed_reports.push_back('{wbss_pkg::KIND_SUMMARY,
				(found == 1) ? first_ofs : {wbss_pkg::OFS_W{1'b0}}, found, st, 1'b1});
			for (i = 0; i < PAT_MAX; i++)
				win[i] = '0;
			pos = '0;
			found = '0;
			next_start = '0;
			first_ofs = '0;
			fill = 0;
		end
	endtask

	task automatic write_reg(input logic [wbss_pkg::REG_IDX_W-1:0] idx,
		input logic [wbss_pkg::WORD_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			wbss_pkg::REG_LENGTH:  cfg_len = value[wbss_pkg::LEN_W-1:0];
			wbss_pkg::REG_PAT_LO:  cfg_pat[0] = value;
			wbss_pkg::REG_PAT_MID: cfg_pat[1] = value;
			wbss_pkg::REG_PAT_HI:  cfg_pat[2] = value;
			wbss_pkg::REG_PAT_TOP: cfg_pat[3] = value;
			wbss_pkg::REG_LIMIT:   cfg_limit = value[wbss_pkg::TOTAL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_scan(input logic [wbss_pkg::WORD_W-1:0] len_word,
		input logic [wbss_pkg::WORD_W-1:0] limit_word);
		write_reg(wbss_pkg::REG_LENGTH, len_word);
		write_reg(wbss_pkg::REG_PAT_LO, pattern_word(0));
		write_reg(wbss_pkg::REG_PAT_MID, pattern_word(1));
		write_reg(wbss_pkg::REG_PAT_HI, pattern_word(2));
		write_reg(wbss_pkg::REG_PAT_TOP, pattern_word(3));
		write_reg(wbss_pkg::REG_LIMIT, limit_word);
		if ($urandom_range(0, 2) == 0) begin
			write_reg(REG_UNMAPPED_A, {$urandom, $urandom});
			write_reg(REG_UNMAPPED_B, {$urandom, $urandom});
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_byte(input logic [wbss_pkg::BYTE_W-1:0] d, input logic fin);
		region_bytes_q.push_back('{d, fin});
		queued_bytes++;
	endtask

	// random region with copies of the pattern planted at random spots
	task automatic queue_region(input int rlen, input int plant_pct);
		int i;
		int j;
		int n;
		n = used_len();
		i = 0;
		while (i < rlen) begin
			if (i + n <= rlen && $urandom_range(0, 99) < plant_pct) begin
				for (j = 0; j < n; j++)
					queue_byte((pat_gen[j] != 0) ? pat_gen[j] : data_pick(), i + j == rlen - 1);
				i += n;
			end else begin
				queue_byte(data_pick(), i == rlen - 1);
				i++;
			end
		end
	endtask

	task automatic wait_idle();
		while (accepted_bytes != queued_bytes || owed_reports.size() != 0)
			@(posedge clk);
		// bytes with no report may still be in flight
		repeat (8) @(posedge clk);
	endtask

	// byte sender: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		region_byte_t nxt;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				scan_byte(byte_ch.data_byte, byte_ch.final_byte);
				accepted_bytes++;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_ch.valid <= 1'b0;
				end else if (region_bytes_q.size() != 0) begin
					nxt = region_bytes_q.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= nxt.data;
					byte_ch.final_byte <= nxt.last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// report receiver: changing stall modes, plus long hold-offs on request
	int hold_left = 0;
	int mode = 0;
	int mode_left = 0;
	logic [31:0] stall_bits = '1;
	always @(posedge clk) begin
		if (!arst_n) begin
			report_ch.ready <= 1'b0;
			mode_left = 0;
			hold_left = 0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			report_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			report_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
				stall_bits = $urandom;
			end
			mode_left--;
			stall_bits = {stall_bits[0], stall_bits[31:1]};
			case (mode)
				0: report_ch.ready <= 1'b1;
				1: report_ch.ready <= stall_bits[0];
				2: report_ch.ready <= ($urandom_range(0, 3) == 0);
				default: report_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// report checker
	always @(posedge clk) begin
		scan_report_t want;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (owed_reports.size() == 0) begin
				$error("report with none owed: kind %0d offset %0h total %0d",
					report_ch.report_kind, report_ch.match_offset, report_ch.match_total);
				mismatches++;
			end else begin
				want = owed_reports.pop_front();
				if (report_ch.report_kind !== want.kind) begin
					$error("report_kind exp %0d got %0d", want.kind, report_ch.report_kind);
					mismatches++;
				end
				if (report_ch.match_offset !== want.ofs) begin
					$error("match_offset exp %0h got %0h", want.ofs, report_ch.match_offset);
					mismatches++;
				end
				if (report_ch.match_total !== want.total) begin
					$error("match_total exp %0d got %0d", want.total, report_ch.match_total);
					mismatches++;
				end
				if (report_ch.scan_status !== want.status) begin
					$error("scan_status exp %0d got %0d", want.status, report_ch.scan_status);
					mismatches++;
				end
				if (report_ch.run_end !== want.run_end) begin
					$error("run_end exp %0d got %0d", want.run_end, report_ch.run_end);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[wildcard_byte_signature_scan] ERROR");
			$finish;
		end
	end

	initial begin
		int k;
		int r;
		int nreg;
		int rlen;
		int phase_no;
		logic [wbss_pkg::WORD_W-1:0] len_word;
		logic [wbss_pkg::WORD_W-1:0] limit_word;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.final_byte = 1'b0;
		report_ch.ready = 1'b0;
		for (k = 0; k < PAT_MAX; k++)
			pat_gen[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: one wildcard byte, so every byte matches
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h80, 1'b1);
		wait_idle();

		// length zero acts as one; upper bits of the length and limit words are dropped
		pat_gen[0] = 8'h5A;
		program_scan(64'hFFFF_FFFF_FFFF_FFC0, 64'hFFFF_FFFF_FFFF_0000);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h02, 1'b0);
		queue_byte(8'h03, 1'b1);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'h22, 1'b1);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'h5A, 1'b1);
		wait_idle();

		// oversize length clamps to full width; match window ends on the final byte
		for (k = 0; k < PAT_MAX; k++)
			pat_gen[k] = (k % 7 == 3) ? 8'h00 : 8'hFF - 8'(k);
		program_scan(64'd63, 64'd65535);
		queue_byte(8'h00, 1'b0);
		for (k = 0; k < PAT_MAX; k++)
			queue_byte((pat_gen[k] != 0) ? pat_gen[k] : data_pick(), k == PAT_MAX - 1);
		wait_idle();

		// no overlap between matches, then the limit cuts reporting off
		for (k = 0; k < PAT_MAX; k++)
			pat_gen[k] = '0;
		pat_gen[0] = 8'h41;
		program_scan(64'd2, 64'd2);
		repeat (4) queue_byte(8'h41, 1'b0);
		queue_byte(8'h41, 1'b1);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h42, 1'b1);
		wait_idle();

		// every byte matches; a long hold-off fills the block and stalls the sender
		for (k = 0; k < PAT_MAX; k++)
			pat_gen[k] = '0;
		program_scan(64'd1, 64'd0);
		queue_region(40, 0);
		hold_requests++;
		wait_idle();

		phase_no = 0;
		while (random_items < 1900) begin
			for (k = 0; k < PAT_MAX; k++)
				pat_gen[k] = pat_pick();
			r = $urandom_range(0, 9);
			if (r == 0)
				len_word = 64'd0;
			else if (r == 1)
				len_word = 64'($urandom_range(33, 63));
			else if (r == 2)
				len_word = 64'd32;
			else if (r == 3)
				len_word = 64'($urandom_range(9, 31));
			else
				len_word = 64'($urandom_range(1, 8));
			if ($urandom_range(0, 3) == 0)
				len_word[wbss_pkg::WORD_W-1:wbss_pkg::LEN_W] = {$urandom, 26'($urandom)};
			r = $urandom_range(0, 9);
			if (r < 6)
				limit_word = 64'd0;
			else if (r < 8)
				limit_word = 64'($urandom_range(1, 3));
			else if (r == 8)
				limit_word = 64'd65535;
			else
				limit_word = 64'($urandom_range(0, 65535));
			program_scan(len_word, limit_word);
			nreg = $urandom_range(2, 5);
			for (k = 0; k < nreg; k++) begin
				rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
				if (used_len() > 8 && $urandom_range(0, 1) == 0)
					rlen += used_len();
				queue_region(rlen, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(10, 50));
				random_items += rlen;
				// receiver holds off while the sender keeps offering bytes
				if (phase_no == 2 && k == 0)
					hold_requests++;
			end
			wait_idle();
			phase_no++;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[wildcard_byte_signature_scan] OK");
		else
			$display("[wildcard_byte_signature_scan] ERROR");
		$finish;
	end

endmodule

// File: wildcard_byte_signature_scan.f
sv/wbss_pkg.sv
sv/wbss_byte_if.sv
sv/wbss_report_if.sv
sv/wbss_front.sv
sv/wbss_queue.sv
sv/wbss_back.sv
sv/wildcard_byte_signature_scan.sv
dv/tb.sv
